@@ sv/spd_pkg.sv @@
// Package for the sensor packet deframer: parser phase type, result kind codes,
// result structure and frame-format constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_BAD     = 2'd2;

    // Frame layout: nine header bytes, two trailing checksum bytes.
    localparam int unsigned POS_W       = 17;
    localparam logic [POS_W-1:0] HDR_LEN     = 17'd9;
    localparam logic [POS_W-1:0] POS_SECOND  = 17'd1;
    localparam logic [POS_W-1:0] POS_TYPE    = 17'd6;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd7;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd8;
    localparam logic [15:0]      MIN_LENGTH  = 16'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  packet_type;
        logic [15:0] payload_length;
    } spd_result_t;

endpackage

`default_nettype wire

@@ sv/sensor_packet_deframer_unit.sv @@
// Top level of the sensor packet deframer: configuration register, frame
// parser and output skid stage. Depends on spd_pkg, spd_parse, spd_out_skid.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one received serial byte per input beat (in_valid, in_stall,
// rx_byte) and gives at most one result beat per input byte on the output
// channel (out_valid, out_stall, kind, data_byte, packet_type, payload_length).
// Bytes are discarded until the high byte of start_code is seen; the nine-byte
// header is then collected, each payload byte is passed on as a kind-0 beat,
// and after the two checksum bytes a kind-1 beat carries the type and payload
// length. A wrong second start byte or a length field below two gives a kind-2
// beat and the parser returns to hunting.
// Throughput is one byte per cycle while in_stall is low: the parser state
// updates in the cycle a byte is accepted, and its result is written straight
// into the output register, or into the skid stage while the output waits.
// When the receiver stalls, the output register holds its beat and one more
// result is caught in a skid stage; only while that stage is full is in_stall
// raised, so the sender is held from when it fills until the output is taken.
// Reset (rst_n, asynchronous) returns the parser to hunting, empties both
// output stages and sets start_code to 0xEF01. start_code is written through
// the APB-style port at byte address 0 and should be changed only while idle.
module sensor_packet_deframer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       data_byte,
    output logic [7:0]       packet_type,
    output logic [15:0]      payload_length
);
    import spd_pkg::*;

    localparam logic [15:0] START_CODE_RESET = 16'hEF01;

    logic [15:0]  start_code_reg, start_code_next;
    logic         cfg_write;
    logic         cfg_hit;
    logic         in_accept;
    logic         res_valid;
    spd_result_t  res;
    spd_result_t  out_data;
    logic         skid_full;

    // Only the start code register exists; paddr[2] selects the word, so a
    // write to the upper word is ignored and reads back as zero.
    assign pready    = 1'b1;
    assign cfg_hit   = !paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? {16'd0, start_code_reg} : 32'd0;

    always_comb
    begin
        start_code_next = start_code_reg;
        if (cfg_write && cfg_hit)
            start_code_next = pwdata[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_code_reg <= START_CODE_RESET;
        else
            start_code_reg <= start_code_next;
    end

    // A byte is taken whenever the skid stage has room.
    assign in_stall  = skid_full;
    assign in_accept = in_valid && !in_stall;

    spd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_accept),
        .rx_byte    (rx_byte),
        .start_code (start_code_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    spd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign data_byte      = out_data.data_byte;
    assign packet_type    = out_data.packet_type;
    assign payload_length = out_data.payload_length;

    // Only the three defined result kinds ever leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_PAYLOAD || kind == KIND_DONE || kind == KIND_BAD))
        else $error("undefined result kind");

    // The length is only reported on a completion beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DONE |-> payload_length == 16'd0)
        else $error("payload length on non-completion beat");

    // The data byte is zero on anything other than a payload beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_PAYLOAD |-> data_byte == 8'd0)
        else $error("data byte on non-payload beat");

    // The sender is only held back while a result waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire

@@ sv/spd_parse.sv @@
// Frame parser of the sensor packet deframer: holds the framing state and
// turns each accepted byte into at most one result beat. Depends on spd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spd_parse (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    input  wire logic [7:0]          rx_byte,
    input  wire logic [15:0]         start_code,
    output logic                     res_valid,
    output spd_pkg::spd_result_t     res
);
    import spd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        second_reg, second_next;
    logic [7:0]        type_reg, type_next;
    logic [15:0]       length_reg, length_next;

    logic [15:0]       plen;
    logic [POS_W-1:0]  body_end;
    logic [15:0]       new_length;
    logic              header_bad;

    assign plen       = length_reg - MIN_LENGTH;
    assign body_end   = HDR_LEN + {1'b0, plen};
    assign new_length = {length_reg[15:8], rx_byte};
    assign header_bad = (second_reg != start_code[7:0]) || (new_length < MIN_LENGTH);

    // Next-state logic.
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        second_next = second_reg;
        type_next   = type_reg;
        length_next = length_reg;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    pos_next = pos_reg + 17'd1;
                    if (pos_reg == POS_SECOND)
                        second_next = rx_byte;
                    if (pos_reg == POS_TYPE)
                        type_next = rx_byte;
                    if (pos_reg == POS_LEN_HI)
                        length_next = {rx_byte, length_reg[7:0]};
                    if (pos_reg == POS_LEN_LO)
                    begin
                        length_next = new_length;
                        if (header_bad)
                        begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                        end
                        else
                            phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    pos_next = pos_reg + 17'd1;
                    if (pos_reg > body_end)
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                    end
                end
                default:
                begin
                    if (rx_byte == start_code[15:8])
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = 17'd1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                    end
                end
            endcase
        end
    end

    // Result logic.
    always_comb
    begin
        res_valid          = 1'b0;
        res.kind           = KIND_PAYLOAD;
        res.data_byte      = '0;
        res.packet_type    = type_reg;
        res.payload_length = '0;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_LEN_LO && header_bad)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_BAD;
                    end
                end
                PH_BODY:
                begin
                    if (pos_reg < body_end)
                    begin
                        res_valid     = 1'b1;
                        res.data_byte = rx_byte;
                    end
                    else if (pos_reg > body_end)
                    begin
                        res_valid          = 1'b1;
                        res.kind           = KIND_DONE;
                        res.payload_length = plen;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            pos_reg    <= '0;
            second_reg <= '0;
            type_reg   <= '0;
            length_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            second_reg <= second_next;
            type_reg   <= type_next;
            length_reg <= length_next;
        end
    end

    // The body is only entered with a length of at least two.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> length_reg >= MIN_LENGTH)
        else $error("body phase with length below two");

    // While hunting the position counter rests at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> pos_reg == '0)
        else $error("position not cleared while hunting");

    // The header never runs past its ninth byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> (pos_reg != '0 && pos_reg < HDR_LEN))
        else $error("header position out of range");

endmodule

`default_nettype wire

@@ sv/spd_out_skid.sv @@
// Output register with one skid stage for the deframer's result channel.
// Depends on spd_pkg for the result structure.
`timescale 1ns / 1ps
`default_nettype none

module spd_out_skid (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire spd_pkg::spd_result_t push_data,
    output logic                      full,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output spd_pkg::spd_result_t      out_data
);
    import spd_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    spd_result_t  out_data_reg, out_data_next;
    spd_result_t  skid_data_reg, skid_data_next;
    logic         take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                if (push)
                    out_data_next = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The skid stage only holds a beat behind a waiting output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with empty output register");

    // A push is never offered while the skid stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("push into full skid stage");

    // A skid beat moves forward as soon as the output is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && take |=> out_valid_reg && !skid_valid_reg)
        else $error("skid beat not forwarded");

endmodule

`default_nettype wire
